// File: rtl/rppcd_pkg.sv
// Package for the remote peek/poke command decoder.
// Holds command ids, return codes, size codes and the result word layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rppcd_pkg;

   localparam int unsigned REQ_DATA_W = 96;
   localparam int unsigned RSP_DATA_W = 120;

   // command ids, bits 14..9 of the command word
   localparam logic [5:0] CMD_NOOP      = 6'd0;
   localparam logic [5:0] CMD_CTRL_READ = 6'd1;
   localparam logic [5:0] CMD_SET_BASE  = 6'd3;
   localparam logic [5:0] CMD_PEEK8     = 6'd4;
   localparam logic [5:0] CMD_PEEK16    = 6'd5;
   localparam logic [5:0] CMD_PEEK32    = 6'd6;
   localparam logic [5:0] CMD_POKE8     = 6'd8;
   localparam logic [5:0] CMD_POKE16    = 6'd9;
   localparam logic [5:0] CMD_POKE32    = 6'd10;

   // return codes, low byte of the reply command
   localparam logic [7:0] RC_MISALIGNED = 8'h00;
   localparam logic [7:0] RC_DONE       = 8'h01;
   localparam logic [7:0] RC_BAD        = 8'hFF;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   localparam logic REQ_KIND_HOST = 1'b0;
   localparam logic REQ_KIND_RDATA = 1'b1;

   // rsp tdata layout, lowest field at the bottom of the struct
   typedef struct packed {
      logic [3:0]  pad;
      logic [15:0] reply_param_high;
      logic [15:0] reply_param_low;
      logic [15:0] reply_command;
      logic        reply_has_command;
      logic [31:0] mem_write_data;
      logic [31:0] mem_address;
      logic [1:0]  mem_size_code;
      logic        mem_write;
   } rsp_data_type;

   typedef struct packed {
      logic         is_reply;
      logic         last;
      rsp_data_type data;
   } res_type;

   function automatic logic [31:0] size_mask(input logic [1:0] size);
      logic [31:0] m;
      case (size)
         SIZE_BYTE: m = 32'h0000_00FF;
         SIZE_HALF: m = 32'h0000_FFFF;
         default:   m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic logic is_aligned(input logic [31:0] addr, input logic [1:0] size);
      logic ok;
      case (size)
         SIZE_BYTE: ok = 1'b1;
         SIZE_HALF: ok = ~addr[0];
         default:   ok = (addr[1:0] == 2'b00);
      endcase
      return ok;
   endfunction

endpackage

`default_nettype wire

// File: rtl/remote_peek_poke_command_decoder.sv
// Remote peek/poke command decoder, top level.
// Uses rppcd_pkg for codes and the result word layout.
//
// Usage: host command accesses and memory read returns arrive as words on the
// req_ stream (tuser 0 = host access, 1 = read return). Results leave on the
// rsp_ stream: tuser 1 marks a host reply, 0 a memory request; tlast marks the
// final word caused by one input word. csr_we/csr_wdata set memory_attached;
// the user must write it only while the block is idle, which the block
// itself does not enforce. Each accepted word is registered in the input
// register, decoded, and its results written to the two-entry result
// buffer. One input word per cycle while its results fit in that buffer; an
// aligned poke with memory attached gives two result words (write request,
// then reply). The result buffer sets the rate: an input is decoded only when its results fit in it.
// Reset (synchronous) clears base address, pending peek, memory_attached and
// all valid flags. If the receiver stalls, up to two results wait in the
// buffer, one more word waits in the input register, then req_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module remote_peek_poke_command_decoder (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // command_word, offset_low, param_low, param_high, read_data
   input  wire logic [rppcd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // mem_write, mem_size_code, mem_address, mem_write_data, reply_has_command,
   // reply_command, reply_param_low, reply_param_high, zero pad
   output logic [rppcd_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // is_reply
   output logic                                    rsp_tuser,
   output logic                                    rsp_tlast,
   input  wire logic                               csr_we,
   input  wire logic                               csr_wdata
);

   logic        in_valid_ff, in_valid_in;
   logic        in_type_ff;
   logic [15:0] in_cw_ff, in_off_ff, in_plo_ff, in_phi_ff;
   logic [31:0] in_rdata_ff;

   logic        attached_ff;
   logic [31:0] base_ff, base_in;
   logic        pending_ff, pending_in;
   logic [1:0]  pending_size_ff, pending_size_in;
   logic [5:0]  pending_id_ff, pending_id_in;

   rppcd_pkg::res_type a_ff, a_in, b_ff, b_in, r0, r1;
   logic        a_valid_ff, a_valid_in, b_valid_ff, b_valid_in;

   logic [1:0]  nres;
   logic        pop, proc, fits;
   logic [1:0]  occ;
   logic [5:0]  id;
   logic [31:0] addr, pdata;
   logic [1:0]  size;
   logic [15:0] echo;

   assign pop  = a_valid_ff & rsp_tready;
   assign occ  = {1'b0, a_valid_ff} + {1'b0, b_valid_ff} - {1'b0, pop};
   assign fits = ({1'b0, occ} + {1'b0, nres}) <= 3'd2;
   assign proc = in_valid_ff & fits;
   assign req_tready = ~in_valid_ff | proc;

   assign id    = in_cw_ff[14:9];
   assign echo  = {1'b0, in_cw_ff[14:9], 9'd0};
   assign addr  = {7'd0, in_cw_ff[8:0], in_off_ff} + base_ff;
   assign size  = id[1:0];
   assign pdata = {in_phi_ff, in_plo_ff};

   // decode
   always_comb begin
      logic [31:0] d;
      d               = in_rdata_ff & rppcd_pkg::size_mask(pending_size_ff);
      r0              = '0;
      r1              = '0;
      nres            = 2'd1;
      base_in         = base_ff;
      pending_in      = pending_ff;
      pending_size_in = pending_size_ff;
      pending_id_in   = pending_id_ff;
      r0.is_reply     = 1'b1;
      r0.last         = 1'b1;
      if (in_type_ff == rppcd_pkg::REQ_KIND_RDATA) begin
         if (!pending_ff) begin
            nres = 2'd0;
         end else begin
            pending_in                    = 1'b0;
            r0.data.reply_has_command     = 1'b1;
            r0.data.reply_command         = {1'b0, pending_id_ff, 9'd0}
                                            | {8'd0, rppcd_pkg::RC_DONE};
            r0.data.reply_param_low       = d[15:0];
            r0.data.reply_param_high      = d[31:16];
         end
      end else if (in_cw_ff[15]) begin
         pending_in                = 1'b0;
         r0.data.reply_has_command = 1'b1;
         r0.data.reply_command     = echo | {8'd0, rppcd_pkg::RC_DONE};
         unique case (id) inside
            rppcd_pkg::CMD_NOOP, rppcd_pkg::CMD_CTRL_READ: begin
            end
            rppcd_pkg::CMD_SET_BASE: begin
               base_in = pdata;
            end
            rppcd_pkg::CMD_PEEK8, rppcd_pkg::CMD_PEEK16, rppcd_pkg::CMD_PEEK32,
            rppcd_pkg::CMD_POKE8, rppcd_pkg::CMD_POKE16, rppcd_pkg::CMD_POKE32: begin
               if (!rppcd_pkg::is_aligned(addr, size)) begin
                  r0.data.reply_command = echo | {8'd0, rppcd_pkg::RC_MISALIGNED};
               end else if (attached_ff) begin
                  r0                    = '0;
                  r0.data.mem_write     = id[3];
                  r0.data.mem_size_code = size;
                  r0.data.mem_address   = addr;
                  if (id[3]) begin
                     r0.data.mem_write_data = pdata & rppcd_pkg::size_mask(size);
                     nres                      = 2'd2;
                     r1.is_reply               = 1'b1;
                     r1.last                   = 1'b1;
                     r1.data.reply_has_command = 1'b1;
                     r1.data.reply_command     = echo | {8'd0, rppcd_pkg::RC_DONE};
                  end else begin
                     r0.last         = 1'b1;
                     pending_in      = 1'b1;
                     pending_size_in = size;
                     pending_id_in   = id;
                  end
               end
            end
            default: begin
               r0.data.reply_command = echo | {8'd0, rppcd_pkg::RC_BAD};
            end
         endcase
      end
   end

   // result buffer
   always_comb begin
      a_in       = a_ff;
      b_in       = b_ff;
      a_valid_in = a_valid_ff;
      b_valid_in = b_valid_ff;
      if (pop) begin
         a_in       = b_ff;
         a_valid_in = b_valid_ff;
         b_valid_in = 1'b0;
      end
      if (proc && nres != 2'd0) begin
         if (!a_valid_in) begin
            a_in       = r0;
            a_valid_in = 1'b1;
            if (nres == 2'd2) begin
               b_in       = r1;
               b_valid_in = 1'b1;
            end
         end else begin
            b_in       = r0;
            b_valid_in = 1'b1;
         end
      end
   end

   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         a_valid_ff      <= 1'b0;
         b_valid_ff      <= 1'b0;
         attached_ff     <= 1'b0;
         base_ff         <= '0;
         pending_ff      <= 1'b0;
         pending_size_ff <= '0;
         pending_id_ff   <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         a_valid_ff  <= a_valid_in;
         b_valid_ff  <= b_valid_in;
         if (csr_we) begin
            attached_ff <= csr_wdata;
         end
         if (proc) begin
            base_ff         <= base_in;
            pending_ff      <= pending_in;
            pending_size_ff <= pending_size_in;
            pending_id_ff   <= pending_id_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_type_ff  <= req_tuser;
         in_cw_ff    <= req_tdata[15:0];
         in_off_ff   <= req_tdata[31:16];
         in_plo_ff   <= req_tdata[47:32];
         in_phi_ff   <= req_tdata[63:48];
         in_rdata_ff <= req_tdata[95:64];
      end
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign rsp_tvalid = a_valid_ff;
   assign rsp_tdata  = a_ff.data;
   assign rsp_tuser  = a_ff.is_reply;
   assign rsp_tlast  = a_ff.last;

endmodule

`default_nettype wire

// File: rtl/rppcd_checker.sv
// Port-level checks for the remote peek/poke command decoder.
// Depends on rppcd_pkg; bound to remote_peek_poke_command_decoder below.
`timescale 1ns / 1ps
`default_nettype none

module rppcd_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [rppcd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic                               rsp_tuser,
   input wire logic                               rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   a_reply_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("reply word without tlast");

   a_reply_no_mem: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[66:0] == 67'd0)
      else $error("reply word carries request fields");

   a_req_no_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[119:67] == 53'd0)
      else $error("request word carries reply fields");

   a_req_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast == !rsp_tdata[0])
      else $error("write request must precede its reply, read request ends");

endmodule

bind remote_peek_poke_command_decoder rppcd_checker u_rppcd_checker (.*);

`default_nettype wire
